// File: design/etb_pkg.sv
// Package for the enveloped tone beeper: sequencer state, register indexes,
// register reset values and the sine table builder.
// No dependencies; used by etb_sine_rom and enveloped_tone_beeper.
package etb_pkg;

  // Width of the configuration write data and of the phase step register
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned STEP_W = 32;

  // Register reset values
  localparam logic [31:0] RST_PHASE_STEP   = 32'd39370534;
  localparam logic [31:0] RST_RAMP_LENGTH  = 32'd19200;
  localparam logic [31:0] RST_BEEP_LENGTH  = 32'd72000;
  localparam logic [31:0] RST_BREAK_LENGTH = 32'd24000;

  // Fixed point helpers for the table builder
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PHASE_STEP,
    REG_RAMP_LENGTH,
    REG_BEEP_LENGTH,
    REG_BREAK_LENGTH
  } etb_reg_t;

  // Sample sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } etb_state_t;

  // Magnitude of sine table entry k (Horner series in Q30, rounded to frac bits,
  // saturated). Evaluated at elaboration only.
  function automatic logic [63:0] sine_mag(input int unsigned k,
                                           input int unsigned tbits,
                                           input int unsigned frac);
    logic [63:0] quarter;
    logic [63:0] quad;
    logic [63:0] r;
    logic [63:0] a;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] v;
    logic [63:0] vmax;
    quarter = 64'd1 << (tbits - 2);
    quad    = (64'(k) >> (tbits - 2)) & 64'd3;
    r       = 64'(k) & (quarter - 64'd1);
    a       = quad[0] ? (quarter - r) : r;
    x       = (a * HALF_PI_Q30) >> (tbits - 2);
    x2      = (x * x) >> 30;
    t       = Q30_ONE - x2 / 64'd72;
    t       = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t       = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t       = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    v       = (x * t) >> 30;
    v       = (v + (64'd1 << (29 - frac))) >> (30 - frac);
    vmax    = (64'd1 << frac) - 64'd1;
    if (v > vmax) begin
      v = vmax;
    end
    return v;
  endfunction

endpackage

// File: design/etb_sine_rom.sv
// Full-wave sine magnitude ROM with registered read.
// Contents built at elaboration by etb_pkg::sine_mag; sign is taken from the
// top phase bit by the user.
module etb_sine_rom #(
  parameter int unsigned TABLE_BITS = 10,
  parameter int unsigned MAG_BITS   = 15
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [TABLE_BITS-1:0] rd_addr,
  output logic [MAG_BITS-1:0]   rd_data
);

  localparam int unsigned DEPTH = 1 << TABLE_BITS;

  logic [MAG_BITS-1:0] rom_w [DEPTH];
  logic [MAG_BITS-1:0] rd_data_r;

  // Constant table contents
  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    assign rom_w[k] = MAG_BITS'(etb_pkg::sine_mag(k, TABLE_BITS, MAG_BITS));
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rom_w[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/enveloped_tone_beeper.sv
// Flow: a tick in the fade-in or fade-out gives its sample after the input transfer
// through the restoring envelope divider (one quotient bit a cycle), then one multiply
// and one output load; at full level the divider is skipped, in the break both are.
// A new tick is taken only after the previous sample is loaded into the output.
// A tick of zero is taken without leaving idle and gives no sample.
// Reset (synchronous, rst_n low): phase and position cleared, registers to defaults.
module enveloped_tone_beeper #(
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned SAMPLE_BITS     = 16,
  parameter int unsigned COUNT_BITS      = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [etb_pkg::CFG_W-1:0]     cfg_wdata,
  // tick input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_tick,
  // sample output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_in_beep
);

  localparam int unsigned FRAC  = SAMPLE_BITS - 1;
  localparam int unsigned CB    = COUNT_BITS;
  localparam int unsigned PW    = 2 * FRAC + 1;
  localparam int unsigned CNT_W = $clog2(SAMPLE_BITS);
  localparam logic [FRAC:0] ENV_ONE = (FRAC + 1)'(1) << FRAC;

  etb_pkg::etb_state_t state_r, state_nxt;

  logic [etb_pkg::STEP_W-1:0] step_cfg_r;
  logic [CB-1:0]              ramp_cfg_r;
  logic [CB-1:0]              beep_cfg_r;
  logic [CB-1:0]              brk_cfg_r;

  logic [PHASE_BITS-1:0] phase_acc_r, phase_acc_nxt;
  logic [CB:0]           pos_r, pos_nxt;
  logic [CB:0]           rem_r, rem_nxt;
  logic [FRAC:0]         quot_r, quot_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic                  tone_r, tone_nxt;
  logic [PW-1:0]         prod_r, prod_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;
  logic                          out_in_beep_r, out_in_beep_nxt;

  logic                   in_acc;
  logic                   slot_free;
  logic [FRAC-1:0]        rom_data;
  logic [CB:0]            total;
  logic [CB:0]            pos_inc;
  logic [CB:0]            pos_wrap;
  logic                   pos_in_beep;
  logic                   ramp_up;
  logic                   ramp_dn;
  logic [CB+1:0]          diff;
  logic                   ge;
  logic [CB:0]            rem_sel;
  logic [SAMPLE_BITS-1:0] mag_s;

  // Sine table, read at the transfer with the phase before it advances
  etb_sine_rom #(
    .TABLE_BITS(SINE_TABLE_BITS),
    .MAG_BITS  (FRAC)
  ) u_rom (
    .clk    (clk),
    .rd_en  (in_acc),
    .rd_addr(phase_acc_r[PHASE_BITS-1 -: SINE_TABLE_BITS]),
    .rd_data(rom_data)
  );

  assign in_acc    = in_valid && (state_r == etb_pkg::ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  // Position bookkeeping and envelope segment tests
  assign total       = {1'b0, beep_cfg_r} + {1'b0, brk_cfg_r};
  assign pos_inc     = pos_r + (CB + 1)'(1);
  assign pos_wrap    = (pos_inc >= total) ? '0 : pos_inc;
  assign pos_in_beep = pos_r < {1'b0, beep_cfg_r};
  assign ramp_up     = pos_r < {1'b0, ramp_cfg_r};
  assign ramp_dn     = ({1'b0, pos_r} + {2'b0, ramp_cfg_r}) >= {2'b0, beep_cfg_r};

  // Shared compare-subtract unit of the restoring divider
  assign diff    = {1'b0, rem_r} - {2'b0, ramp_cfg_r};
  assign ge      = !diff[CB+1];
  assign rem_sel = ge ? diff[CB:0] : rem_r;

  // Enveloped magnitude
  assign mag_s = {1'b0, prod_r[2*FRAC-1:FRAC]};

  // Sequencer and datapath next values
  always_comb begin
    state_nxt       = state_r;
    phase_acc_nxt   = phase_acc_r;
    pos_nxt         = pos_r;
    rem_nxt         = rem_r;
    quot_nxt        = quot_r;
    cnt_nxt         = cnt_r;
    neg_nxt         = neg_r;
    tone_nxt        = tone_r;
    prod_nxt        = prod_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_sample_nxt  = out_sample_r;
    out_in_beep_nxt = out_in_beep_r;
    unique case (state_r)
      etb_pkg::ST_IDLE: begin
        if (in_acc && in_tick) begin
          pos_nxt = pos_wrap;
          if (pos_in_beep) begin
            tone_nxt      = 1'b1;
            neg_nxt       = phase_acc_r[PHASE_BITS-1];
            phase_acc_nxt = phase_acc_r + PHASE_BITS'(step_cfg_r);
            cnt_nxt       = CNT_W'(FRAC);
            quot_nxt      = '0;
            priority if (ramp_up) begin
              rem_nxt   = {1'b0, pos_r[CB-1:0]};
              state_nxt = etb_pkg::ST_DIV;
            end else if (ramp_dn) begin
              rem_nxt   = {1'b0, beep_cfg_r - pos_r[CB-1:0]};
              state_nxt = etb_pkg::ST_DIV;
            end else begin
              quot_nxt  = ENV_ONE;
              state_nxt = etb_pkg::ST_MUL;
            end
          end else begin
            tone_nxt  = 1'b0;
            state_nxt = etb_pkg::ST_DONE;
          end
        end
      end
      etb_pkg::ST_DIV: begin
        // one quotient bit per cycle, MSB first
        quot_nxt = {quot_r[FRAC-1:0], ge};
        rem_nxt  = {rem_sel[CB-1:0], 1'b0};
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = etb_pkg::ST_MUL;
        end
      end
      etb_pkg::ST_MUL: begin
        prod_nxt  = PW'(rom_data) * PW'(quot_r);
        state_nxt = etb_pkg::ST_DONE;
      end
      etb_pkg::ST_DONE: begin
        // wait for the output register to free up
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_in_beep_nxt = tone_r;
          if (!tone_r) begin
            out_sample_nxt = '0;
          end else if (neg_r) begin
            out_sample_nxt = -mag_s;
          end else begin
            out_sample_nxt = mag_s;
          end
          state_nxt = etb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = etb_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= etb_pkg::ST_IDLE;
      phase_acc_r <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      step_cfg_r  <= etb_pkg::RST_PHASE_STEP;
      ramp_cfg_r  <= CB'(etb_pkg::RST_RAMP_LENGTH);
      beep_cfg_r  <= CB'(etb_pkg::RST_BEEP_LENGTH);
      brk_cfg_r   <= CB'(etb_pkg::RST_BREAK_LENGTH);
    end else begin
      state_r     <= state_nxt;
      phase_acc_r <= phase_acc_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (etb_pkg::etb_reg_t'(cfg_index))
          etb_pkg::REG_PHASE_STEP:   step_cfg_r <= cfg_wdata;
          etb_pkg::REG_RAMP_LENGTH:  ramp_cfg_r <= cfg_wdata[CB-1:0];
          etb_pkg::REG_BEEP_LENGTH:  beep_cfg_r <= cfg_wdata[CB-1:0];
          etb_pkg::REG_BREAK_LENGTH: brk_cfg_r  <= cfg_wdata[CB-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rem_r         <= rem_nxt;
    quot_r        <= quot_nxt;
    cnt_r         <= cnt_nxt;
    neg_r         <= neg_nxt;
    tone_r        <= tone_nxt;
    prod_r        <= prod_nxt;
    out_sample_r  <= out_sample_nxt;
    out_in_beep_r <= out_in_beep_nxt;
  end

  assign in_stall    = (state_r != etb_pkg::ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_in_beep = out_in_beep_r;

endmodule

// File: design/etb_check.sv
// Port-level checker for the enveloped tone beeper, with its bind.
// Depends on enveloped_tone_beeper being compiled first.
module etb_check #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_tick,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_sample,
  input logic                          out_in_beep
);

  // A stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(out_in_beep))
    else $error("stalled result changed");

  // Break samples are silent
  a_break_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_beep |-> out_sample == '0)
    else $error("break sample not zero");

  // A tick keeps the block busy on the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_tick |=> in_stall)
    else $error("block free right after a tick transfer");

  // An empty tick is taken without occupying the block
  a_notick_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_tick |=> !in_stall)
    else $error("block busy after an empty tick");

endmodule

bind enveloped_tone_beeper etb_check #(.SAMPLE_BITS(SAMPLE_BITS)) u_etb_check (.*);
